[rtl/core/stream_reassembly_tracker_defines.svh]
// Assertion macros for the stream reassembly tracker.
// Used by rtl/core modules that check their own control logic; no dependencies.
`ifndef STREAM_REASSEMBLY_TRACKER_DEFINES_SVH
`define STREAM_REASSEMBLY_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRT_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SRT_ASSERT(lbl, prop, msg)
`define SRT_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[rtl/core/srt_pkg.sv]
// Shared types and constants for the stream reassembly tracker.
// No dependencies.
package srt_pkg;

  localparam int unsigned OFF_W         = 62;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned SEG_SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EXTEND,
    FSM_RESP
  } fsm_e;

  typedef enum logic [1:0] {
    RS_RECV        = 2'd0,
    RS_SIZE_KNOWN  = 2'd1,
    RS_DATA_RECVD  = 2'd2,
    RS_RESET_RECVD = 2'd3
  } recv_state_e;

  typedef enum logic [2:0] {
    ST_INSERTED     = 3'd0,
    ST_ALREADY_READ = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_SIZE_ERR     = 3'd3,
    ST_IGNORED      = 3'd4,
    ST_RESET_OK     = 3'd5,
    ST_TABLE_FULL   = 3'd6
  } status_e;

  function automatic logic size_known(recv_state_e rs);
    return (rs == RS_SIZE_KNOWN) || (rs == RS_DATA_RECVD);
  endfunction

endpackage

[rtl/core/stream_reassembly_tracker.sv]
// Receive reassembly tracker for one stream: segment table, contiguous end, final size.
// Depends on srt_pkg and stream_reassembly_tracker_defines.svh.
//
// Input channel: in_valid_i / in_stall_o carry one request, a data frame (offset,
// length, fin, consumer offset) or a stream reset. Output channel: out_valid_o /
// out_stall_i carry one result per request: status, contiguous end, final size,
// receive state, ready-to-read and all-received.
// Resets, repeated resets, frames after reset, overflow, final size errors and
// stale frames go from acceptance straight to the result without a memory walk.
// Other data frames walk the segment memory with one read port: one scan pass for
// the duplicate search and free slot, then, unless the frame is a duplicate or the
// table is full, one or more merge passes until the contiguous end stops growing.
// The number of merge passes is 1 when the new segment merges nothing, otherwise
// one more than the passes in which the end grew, at most SEG_SLOTS+1.
// One request is worked on at a time; in_stall_o is high while it is in flight.
// The result sits in an output register: a new request is taken while it waits,
// and a stalled receiver only holds back the next result.
// Reset empties the table (valid bits only), clears the contiguous end and final
// size and puts the stream in the receive state. No clearing pass is needed.
`include "stream_reassembly_tracker_defines.svh"

module stream_reassembly_tracker
  import srt_pkg::*;
#(
  parameter int unsigned SEG_SLOTS = SEG_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [OFF_W-1:0] frame_offset_i,
  input  logic [LEN_W-1:0] frame_length_i,
  input  logic             frame_fin_i,
  input  logic [OFF_W-1:0] consumer_offset_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [OFF_W-1:0] contiguous_end_o,
  output logic [OFF_W-1:0] final_size_out_o,
  output logic [1:0]       recv_state_out_o,
  output logic             ready_to_read_o,
  output logic             all_received_o
);

  localparam int unsigned IW = $clog2(SEG_SLOTS);
  localparam int unsigned CW = $clog2(SEG_SLOTS + 1);

  fsm_e fsm_q, fsm_d;

  logic [OFF_W-1:0] off_q, off_d, end_q, end_d, cons_q, cons_d;
  logic [OFF_W-1:0] ce_q, ce_d, fs_q, fs_d;
  recv_state_e      rs_q, rs_d;

  logic [SEG_SLOTS-1:0] vld_q, vld_d, fm_q, fm_d;
  logic [OFF_W-1:0]     mem_start [SEG_SLOTS];
  logic [OFF_W-1:0]     mem_end   [SEG_SLOTS];

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             rd_en, rd_vld_q;
  logic [IW-1:0]    rd_addr, rd_idx_q;
  logic [OFF_W-1:0] rd_start_q, rd_end_q;
  logic             wr_en;

  logic             near_vld_q, near_vld_d;
  logic [OFF_W-1:0] near_start_q, near_start_d, near_end_q, near_end_d;
  logic             slot_vld_q, slot_vld_d;
  logic [IW-1:0]    slot_q, slot_d;
  logic             grew_q, grew_d;

  status_e status_q, status_d;
  logic    rdy_q, rdy_d;

  logic             out_vld_q, out_vld_d;
  status_e          out_status_q;
  logic [OFF_W-1:0] out_ce_q, out_fs_q;
  recv_state_e      out_rs_q;
  logic             out_rdy_q, out_all_q;

  logic accept, go_scan, pass_done, is_dup, load_out, ev;

  assign accept    = (fsm_q == FSM_IDLE) && in_valid_i;
  assign pass_done = (cnt_q == CW'(SEG_SLOTS)) && !rd_vld_q;
  assign is_dup    = near_vld_q && (end_q <= near_end_q);
  assign load_out  = (fsm_q == FSM_RESP) && (!out_vld_q || !out_stall_i);
  assign ev        = vld_q[rd_idx_q];

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          fsm_d = go_scan ? FSM_SCAN : FSM_RESP;
        end
      end
      FSM_SCAN: begin
        if (pass_done) begin
          fsm_d = (is_dup || !slot_vld_q) ? FSM_RESP : FSM_EXTEND;
        end
      end
      FSM_EXTEND: begin
        if (pass_done && !grew_q) begin
          fsm_d = FSM_RESP;
        end
      end
      FSM_RESP: begin
        if (load_out) begin
          fsm_d = FSM_IDLE;
        end
      end
      default: fsm_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    logic [OFF_W:0]   sum;
    recv_state_e      rs_t;
    logic [OFF_W-1:0] fs_t;
    off_d        = off_q;
    end_d        = end_q;
    cons_d       = cons_q;
    ce_d         = ce_q;
    fs_d         = fs_q;
    rs_d         = rs_q;
    vld_d        = vld_q;
    fm_d         = fm_q;
    cnt_d        = cnt_q;
    rd_en        = 1'b0;
    rd_addr      = cnt_q[IW-1:0];
    wr_en        = 1'b0;
    near_vld_d   = near_vld_q;
    near_start_d = near_start_q;
    near_end_d   = near_end_q;
    slot_vld_d   = slot_vld_q;
    slot_d       = slot_q;
    grew_d       = grew_q;
    status_d     = status_q;
    rdy_d        = rdy_q;
    go_scan      = 1'b0;
    sum          = {1'b0, frame_offset_i} + {{(OFF_W + 1 - LEN_W){1'b0}}, frame_length_i};
    rs_t         = rs_q;
    fs_t         = fs_q;

    if (accept) begin
      off_d      = frame_offset_i;
      end_d      = sum[OFF_W-1:0];
      cons_d     = consumer_offset_i;
      rdy_d      = 1'b0;
      cnt_d      = '0;
      near_vld_d = 1'b0;
      slot_vld_d = 1'b0;
      if (cmd_i) begin
        if (rs_q != RS_RESET_RECVD) begin
          rs_d     = RS_RESET_RECVD;
          vld_d    = '0;
          status_d = ST_RESET_OK;
        end else begin
          status_d = ST_IGNORED;
        end
      end else if (rs_q == RS_RESET_RECVD) begin
        status_d = ST_IGNORED;
      end else if (sum[OFF_W]) begin
        status_d = ST_SIZE_ERR;
      end else if (frame_fin_i && size_known(rs_q) && (fs_q != sum[OFF_W-1:0])) begin
        status_d = ST_SIZE_ERR;
      end else begin
        if (frame_fin_i) begin
          fs_t = sum[OFF_W-1:0];
          rs_t = (rs_q == RS_RECV) ? RS_SIZE_KNOWN : rs_q;
          fs_d = fs_t;
          rs_d = rs_t;
        end
        if (size_known(rs_t) && (sum[OFF_W-1:0] > fs_t)) begin
          status_d = ST_SIZE_ERR;
        end else if (sum[OFF_W-1:0] <= ce_q) begin
          status_d = ST_ALREADY_READ;
        end else begin
          go_scan = 1'b1;
        end
      end
    end

    if ((fsm_q == FSM_SCAN || fsm_q == FSM_EXTEND) && (cnt_q < CW'(SEG_SLOTS))) begin
      rd_en = 1'b1;
      cnt_d = cnt_q + 1'b1;
    end

    if (fsm_q == FSM_SCAN) begin
      if (rd_vld_q) begin
        if (ev && (rd_start_q <= off_q)) begin
          if (!near_vld_q || (rd_start_q > near_start_q) ||
              ((rd_start_q == near_start_q) && (rd_end_q > near_end_q))) begin
            near_vld_d   = 1'b1;
            near_start_d = rd_start_q;
            near_end_d   = rd_end_q;
          end
        end
        fm_d[rd_idx_q] = ev && (rd_end_q <= ce_q);
        if (!slot_vld_q && (!ev || (rd_end_q <= ce_q))) begin
          slot_vld_d = 1'b1;
          slot_d     = rd_idx_q;
        end
      end
      if (pass_done) begin
        if (is_dup) begin
          status_d = ST_DUPLICATE;
        end else begin
          vld_d = vld_q & ~fm_q;
          if (!slot_vld_q) begin
            status_d = ST_TABLE_FULL;
          end else begin
            wr_en         = 1'b1;
            vld_d[slot_q] = 1'b1;
            cnt_d         = '0;
            grew_d        = 1'b0;
          end
        end
      end
    end

    if (fsm_q == FSM_EXTEND) begin
      if (rd_vld_q) begin
        if (ev && (rd_start_q <= ce_q) && (rd_end_q > ce_q)) begin
          ce_d   = rd_end_q;
          grew_d = 1'b1;
        end
        fm_d[rd_idx_q] = ev && (rd_end_q <= ce_q);
      end
      if (pass_done) begin
        if (grew_q) begin
          cnt_d  = '0;
          grew_d = 1'b0;
        end else begin
          vld_d    = vld_q & ~fm_q;
          status_d = ST_INSERTED;
          if (size_known(rs_q) && (fs_q == ce_q)) begin
            if (rs_q == RS_SIZE_KNOWN) begin
              rs_d = RS_DATA_RECVD;
            end
            rdy_d = 1'b1;
          end else if (cons_q < ce_q) begin
            rdy_d = 1'b1;
          end
        end
      end
    end

    out_vld_d = out_vld_q && out_stall_i;
    if (load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= FSM_IDLE;
      ce_q       <= '0;
      fs_q       <= '0;
      rs_q       <= RS_RECV;
      vld_q      <= '0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      near_vld_q <= 1'b0;
      slot_vld_q <= 1'b0;
      grew_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      fsm_q      <= fsm_d;
      ce_q       <= ce_d;
      fs_q       <= fs_d;
      rs_q       <= rs_d;
      vld_q      <= vld_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_en;
      near_vld_q <= near_vld_d;
      slot_vld_q <= slot_vld_d;
      grew_q     <= grew_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q        <= off_d;
    end_q        <= end_d;
    cons_q       <= cons_d;
    fm_q         <= fm_d;
    near_start_q <= near_start_d;
    near_end_q   <= near_end_d;
    slot_q       <= slot_d;
    status_q     <= status_d;
    rdy_q        <= rdy_d;
    if (load_out) begin
      out_status_q <= status_q;
      out_ce_q     <= ce_q;
      out_fs_q     <= fs_q;
      out_rs_q     <= rs_q;
      out_rdy_q    <= rdy_q;
      out_all_q    <= size_known(rs_q) && (ce_q == fs_q);
    end
  end

  // segment memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_start[slot_q] <= off_q;
      mem_end[slot_q]   <= end_q;
    end
    if (rd_en) begin
      rd_start_q <= mem_start[rd_addr];
      rd_end_q   <= mem_end[rd_addr];
      rd_idx_q   <= rd_addr;
    end
  end

  assign in_stall_o       = (fsm_q != FSM_IDLE);
  assign out_valid_o      = out_vld_q;
  assign status_o         = out_status_q;
  assign contiguous_end_o = out_ce_q;
  assign final_size_out_o = out_fs_q;
  assign recv_state_out_o = out_rs_q;
  assign ready_to_read_o  = out_rdy_q;
  assign all_received_o   = out_all_q;

  `SRT_ASSERT_NR(a_rdy_only_insert, (out_vld_q && out_rdy_q) |-> (out_status_q == ST_INSERTED), "ready-to-read on a request that was not inserted")
  `SRT_ASSERT(a_all_needs_size, (out_vld_q && out_all_q) |-> (out_rs_q == RS_SIZE_KNOWN || out_rs_q == RS_DATA_RECVD), "all received without a known final size")
  `SRT_ASSERT(a_ce_monotonic, ce_q >= $past(ce_q), "contiguous end moved backwards")
  `SRT_ASSERT(a_wr_slot_free, wr_en |-> slot_vld_q && !is_dup && (fsm_q == FSM_SCAN), "segment written without a free slot")

endmodule

[sim/stream_reassembly_tracker_tb.sv]
// Self-checking testbench for stream_reassembly_tracker: directed and random requests,
// each checked against an in-bench model of the segment table and receive state.
// Depends on srt_pkg and the stream_reassembly_tracker RTL.
module stream_reassembly_tracker_tb;
  import srt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = SEG_SLOTS_DEF;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic             cmd;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    logic             fin;
    logic [OFF_W-1:0] cons;
  } frame_t;

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] cend;
    logic [OFF_W-1:0] fsize;
    recv_state_e      rs;
    logic             ready;
    logic             allr;
  } verdict_t;

  typedef struct packed {
    frame_t   f;
    verdict_t v;
  } pend_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, cmd_i, frame_fin_i;
  logic [OFF_W-1:0] frame_offset_i, consumer_offset_i;
  logic [LEN_W-1:0] frame_length_i;
  logic out_valid_o, out_stall_i;
  logic [2:0] status_o;
  logic [OFF_W-1:0] contiguous_end_o, final_size_out_o;
  logic [1:0] recv_state_out_o;
  logic ready_to_read_o, all_received_o;

  stream_reassembly_tracker DUT (.*);

  // model of the tracker
  logic [OFF_W-1:0] seg_lo [SLOTS];
  logic [OFF_W-1:0] seg_hi [SLOTS];
  bit               seg_used [SLOTS];
  logic [OFF_W-1:0] cend, fsize;
  recv_state_e      rs;

  pend_t    frame_q[$];
  verdict_t verdicts[$];
  verdict_t cur_verdict;
  int idle_pct, stall_pct, mismatches, cycles;
  bit hold_kick, hold_used;
  int hold_cnt;

  function automatic bit known();
    return rs == RS_SIZE_KNOWN || rs == RS_DATA_RECVD;
  endfunction

  function automatic void free_behind();
    for (int i = 0; i < SLOTS; i++)
      if (seg_used[i] && seg_hi[i] <= cend) seg_used[i] = 0;
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += seg_used[i];
    return n;
  endfunction

  function automatic status_e frame_status(frame_t f, output logic rdy);
    logic [OFF_W:0]   fe;
    logic [OFF_W-1:0] e;
    int nearest, slot;
    bit grew;
    rdy = 0;
    if (rs == RS_RESET_RECVD) return ST_IGNORED;
    fe = {1'b0, f.off} + f.len;
    if (fe[OFF_W]) return ST_SIZE_ERR;
    e = fe[OFF_W-1:0];
    if (f.fin) begin
      if (known() && fsize != e) return ST_SIZE_ERR;
      fsize = e;
      if (rs == RS_RECV) rs = RS_SIZE_KNOWN;
    end
    if (known() && e > fsize) return ST_SIZE_ERR;
    if (e <= cend) return ST_ALREADY_READ;
    nearest = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!seg_used[i] || seg_lo[i] > f.off) continue;
      if (nearest < 0 || seg_lo[i] > seg_lo[nearest] ||
          (seg_lo[i] == seg_lo[nearest] && seg_hi[i] > seg_hi[nearest]))
        nearest = i;
    end
    if (nearest >= 0 && e <= seg_hi[nearest]) return ST_DUPLICATE;
    free_behind();
    slot = -1;
    for (int i = SLOTS - 1; i >= 0; i--) if (!seg_used[i]) slot = i;
    if (slot < 0) return ST_TABLE_FULL;
    seg_lo[slot] = f.off;
    seg_hi[slot] = e;
    seg_used[slot] = 1;
    grew = 1;
    for (int p = 0; p <= SLOTS && grew; p++) begin
      grew = 0;
      for (int i = 0; i < SLOTS; i++)
        if (seg_used[i] && seg_lo[i] <= cend && seg_hi[i] > cend) begin
          cend = seg_hi[i];
          grew = 1;
        end
    end
    free_behind();
    if (known() && fsize == cend) begin
      if (rs == RS_SIZE_KNOWN) rs = RS_DATA_RECVD;
      rdy = 1;
    end else if (f.cons < cend) begin
      rdy = 1;
    end
    return ST_INSERTED;
  endfunction

  function automatic verdict_t absorb(frame_t f);
    verdict_t v;
    logic rdy;
    rdy = 0;
    if (f.cmd) begin
      if (rs != RS_RESET_RECVD) begin
        rs = RS_RESET_RECVD;
        for (int i = 0; i < SLOTS; i++) seg_used[i] = 0;
        v.status = ST_RESET_OK;
      end else begin
        v.status = ST_IGNORED;
      end
    end else begin
      v.status = frame_status(f, rdy);
    end
    v.cend = cend;
    v.fsize = fsize;
    v.rs = rs;
    v.ready = rdy;
    v.allr = known() && cend == fsize;
    return v;
  endfunction

  task automatic add(input logic cmd, input logic [OFF_W-1:0] off,
                     input logic [LEN_W-1:0] len, input logic fin,
                     input logic [OFF_W-1:0] cons);
    pend_t p;
    p.f = '{cmd: cmd, off: off, len: len, fin: fin, cons: cons};
    p.v = absorb(p.f);
    frame_q.push_back(p);
  endtask

  function automatic logic [OFF_W-1:0] back_off(int unsigned span);
    int unsigned d;
    d = $urandom_range(0, span);
    return (cend > d) ? cend - d : '0;
  endfunction

  task automatic add_random();
    logic [OFF_W-1:0] off, cons, top;
    int unsigned len, r, p;
    p = $urandom_range(99);
    r = $urandom_range(3);
    cons = (r == 0) ? OFF_W'({$urandom, $urandom}) : back_off(3);
    if (used_count() >= SLOTS - 2) begin
      // close the lowest gap so the table drains
      top = OFF_MAX;
      for (int i = 0; i < SLOTS; i++)
        if (seg_used[i] && seg_lo[i] > cend && seg_lo[i] < top) top = seg_lo[i];
      off = back_off(20);
      len = 32'(top - off) + $urandom_range(0, 50);
    end else if (p < 40) begin
      off = back_off(40);
      len = $urandom_range(1, 300);
    end else if (p < 75) begin
      off = cend + $urandom_range(1, 1500);
      len = $urandom_range(1, 200);
    end else if (p < 90) begin
      off = back_off(400);
      len = $urandom_range(0, 420);
    end else begin
      r = $urandom_range(0, 65534);
      off = OFF_MAX - r;
      len = $urandom_range(r + 1, 65535);
    end
    add(1'b0, off, len[LEN_W-1:0], 1'b0, cons);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (frame_q.size() != 0 || in_valid_i || verdicts.size() != 0);
  endtask

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    pend_t p;
    if (!rst_ni) begin
      in_valid_i <= 0;
      cmd_i <= 0;
      frame_offset_i <= '0;
      frame_length_i <= '0;
      frame_fin_i <= 0;
      consumer_offset_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) verdicts.push_back(cur_verdict);
      if (!in_valid_i || !in_stall_o) begin
        if (frame_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          p = frame_q.pop_front();
          cur_verdict <= p.v;
          cmd_i <= p.f.cmd;
          frame_offset_i <= p.f.off;
          frame_length_i <= p.f.len;
          frame_fin_i <= p.f.fin;
          consumer_offset_i <= p.f.cons;
          in_valid_i <= 1;
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_used <= 0;
    end else if (hold_kick && !hold_used) begin
      hold_cnt <= 600;
      hold_used <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    verdict_t got, want;
    if (!rst_ni) begin
      out_stall_i <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{status: status_e'(status_o), cend: contiguous_end_o,
                fsize: final_size_out_o, rs: recv_state_e'(recv_state_out_o),
                ready: ready_to_read_o, allr: all_received_o};
        if (verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = verdicts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      out_stall_i <= (hold_cnt > 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("stream_reassembly_tracker test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [OFF_W-1:0] fs;
    int k;
    rst_ni = 0;
    cycles = 0;
    mismatches = 0;
    hold_kick = 0;
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) seg_used[i] = 0;
    cend = '0;
    fsize = '0;
    rs = RS_RECV;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;

    add(0, 0, 0, 0, 0);
    add(0, 0, 100, 0, 0);
    add(0, 10, 20, 0, 0);
    add(0, 200, 50, 0, 500);
    add(0, 210, 10, 0, 0);
    add(0, 200, 60, 0, 0);
    add(0, 205, 55, 0, 0);
    add(0, OFF_MAX, 1, 0, 0);
    add(0, OFF_MAX - 10, 16'hFFFF, 0, OFF_MAX);
    add(0, 100, 100, 0, OFF_MAX);
    add(0, 0, 16'hFFFF, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 58 : 17) : 0;
      stall_pct = (ph == 2) ? 58 : (ph == 3) ? 17 : 0;
      repeat (475) add_random();
      if (ph == 0) begin
        repeat (20) @(negedge clk_i);
        hold_kick = 1;
      end
      drain();
    end

    // final size, table full, then stream reset
    idle_pct = 17;
    stall_pct = 17;
    fs = cend + 5000;
    add(0, cend + 4000, 1000, 1, 0);
    add(0, cend + 4001, 1000, 1, 0);
    add(0, fs - 10, 20, 0, 0);
    k = 1;
    while (used_count() < SLOTS && k < 390) begin
      add(0, cend + 10 * k, 3, 0, OFF_MAX);
      k++;
    end
    add(0, cend + 3995, 2, 0, 0);
    add(0, fs - 1, 1, 1, 0);
    add(1, 0, 0, 0, 0);
    add(1, OFF_MAX, 16'hFFFF, 1, OFF_MAX);
    add(0, 0, 5, 0, 0);
    drain();
    repeat (120) @(negedge clk_i);

    if (mismatches == 0 && verdicts.size() == 0)
      $display("stream_reassembly_tracker test passed");
    else
      $display("stream_reassembly_tracker test failed");
    $finish;
  end
endmodule

[stream_reassembly_tracker.f]
+incdir+rtl/core
rtl/core/srt_pkg.sv
rtl/core/stream_reassembly_tracker.sv
sim/stream_reassembly_tracker_tb.sv
